>>> rtl/ec_host_transaction_sequencer_defines.svh
// ============================================================================
// Assertion macros for the embedded-controller host sequencer
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ============================================================================
`ifndef EC_HOST_TRANSACTION_SEQUENCER_DEFINES_SVH
`define EC_HOST_TRANSACTION_SEQUENCER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EHTS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ehts assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define EHTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ehts assertion failed");

`endif

>>> rtl/ehts_pkg.sv
// ============================================================================
// ehts_pkg
// Types and constants shared by the embedded-controller host sequencer.
// ============================================================================
package ehts_pkg;

   // Request actions.
   localparam logic [2:0] ACT_READ   = 3'd0;
   localparam logic [2:0] ACT_WRITE  = 3'd1;
   localparam logic [2:0] ACT_QUERY  = 3'd2;
   localparam logic [2:0] ACT_SAMPLE = 3'd3;
   localparam logic [2:0] ACT_SCI    = 3'd4;

   // Status register bit positions.
   localparam int ST_OBF_BIT = 0;
   localparam int ST_IBF_BIT = 1;
   localparam int ST_SCI_BIT = 5;

   // Controller commands.
   localparam logic [7:0] CMD_READ  = 8'h80;
   localparam logic [7:0] CMD_WRITE = 8'h81;
   localparam logic [7:0] CMD_QUERY = 8'h84;

   // Poll limit after reset.
   localparam logic [15:0] POLL_RESET = 16'd1000;

   // Completion codes.
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_TIMEOUT = 2'd1;
   localparam logic [1:0] STS_NO_DATA = 2'd2;
   localparam logic [1:0] STS_REJECT  = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_RD_CMD  = 3'd1,
      PH_RD_ADDR = 3'd2,
      PH_WR_CMD  = 3'd3,
      PH_WR_ADDR = 3'd4,
      PH_WR_DATA = 3'd5,
      PH_QUERY   = 3'd6
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] polls_left;
      logic [7:0]  held_address;
      logic [7:0]  held_write_byte;
   } state_type;

   typedef struct packed {
      logic       port_write_valid;
      logic       port_is_data;
      logic [7:0] port_value;
      logic       done_res;
      logic [1:0] status_code;
      logic [7:0] read_data;
      logic       busy_res;
   } result_type;

endpackage

>>> rtl/ehts_step.sv
// ============================================================================
// ehts_step
// Combinational transaction step: from the held state and one input item,
// forms the next state and the result item.
// ============================================================================
module ehts_step (
   input  ehts_pkg::state_type  cur_state,
   input  logic [15:0]          poll_limit,
   input  logic [2:0]           action,
   input  logic [7:0]           address,
   input  logic [7:0]           write_data,
   input  logic [7:0]           status_byte,
   input  logic [7:0]           data_byte,
   output ehts_pkg::state_type  nxt_state,
   output ehts_pkg::result_type result
);

   logic busy;
   logic request;
   logic cond_met;
   logic wait_obf;

   // Classify the item.
   assign busy    = cur_state.phase != ehts_pkg::PH_IDLE;
   assign request = (action == ehts_pkg::ACT_READ) || (action == ehts_pkg::ACT_WRITE) ||
                    (action == ehts_pkg::ACT_QUERY) ||
                    ((action == ehts_pkg::ACT_SCI) && status_byte[ehts_pkg::ST_SCI_BIT]);

   // The read byte and queries wait for output-buffer-full, the other phases for
   // input-buffer-empty.
   assign wait_obf = (cur_state.phase == ehts_pkg::PH_RD_ADDR) ||
                     (cur_state.phase == ehts_pkg::PH_QUERY);
   assign cond_met = wait_obf ? status_byte[ehts_pkg::ST_OBF_BIT]
                              : !status_byte[ehts_pkg::ST_IBF_BIT];

   // Transaction update.
   always_comb begin
      nxt_state = cur_state;
      result    = '0;
      if (request && busy) begin
         result.done_res    = 1'b1;
         result.status_code = ehts_pkg::STS_REJECT;
      end else if (request) begin
         result.port_write_valid = 1'b1;
         nxt_state.polls_left    = poll_limit;
         case (action)
            ehts_pkg::ACT_READ: begin
               nxt_state.held_address = address;
               nxt_state.phase        = ehts_pkg::PH_RD_CMD;
               result.port_value      = ehts_pkg::CMD_READ;
            end
            ehts_pkg::ACT_WRITE: begin
               nxt_state.held_address    = address;
               nxt_state.held_write_byte = write_data;
               nxt_state.phase           = ehts_pkg::PH_WR_CMD;
               result.port_value         = ehts_pkg::CMD_WRITE;
            end
            default: begin
               nxt_state.phase   = ehts_pkg::PH_QUERY;
               result.port_value = ehts_pkg::CMD_QUERY;
            end
         endcase
      end else if ((action == ehts_pkg::ACT_SAMPLE) && busy) begin
         if (!cond_met) begin
            if (cur_state.polls_left <= 16'd1) begin
               nxt_state.polls_left = '0;
               nxt_state.phase      = ehts_pkg::PH_IDLE;
               result.done_res      = 1'b1;
               result.status_code   = ehts_pkg::STS_TIMEOUT;
            end else begin
               nxt_state.polls_left = cur_state.polls_left - 16'd1;
            end
         end else begin
            nxt_state.polls_left = poll_limit;
            case (cur_state.phase)
               ehts_pkg::PH_RD_CMD: begin
                  result.port_write_valid = 1'b1;
                  result.port_is_data     = 1'b1;
                  result.port_value       = cur_state.held_address;
                  nxt_state.phase         = ehts_pkg::PH_RD_ADDR;
               end
               ehts_pkg::PH_RD_ADDR: begin
                  result.done_res  = 1'b1;
                  result.read_data = data_byte;
                  nxt_state.phase  = ehts_pkg::PH_IDLE;
               end
               ehts_pkg::PH_WR_CMD: begin
                  result.port_write_valid = 1'b1;
                  result.port_is_data     = 1'b1;
                  result.port_value       = cur_state.held_address;
                  nxt_state.phase         = ehts_pkg::PH_WR_ADDR;
               end
               ehts_pkg::PH_WR_ADDR: begin
                  result.port_write_valid = 1'b1;
                  result.port_is_data     = 1'b1;
                  result.port_value       = cur_state.held_write_byte;
                  nxt_state.phase         = ehts_pkg::PH_WR_DATA;
               end
               ehts_pkg::PH_WR_DATA: begin
                  result.done_res = 1'b1;
                  nxt_state.phase = ehts_pkg::PH_IDLE;
               end
               ehts_pkg::PH_QUERY: begin
                  result.done_res    = 1'b1;
                  result.read_data   = data_byte;
                  result.status_code = (data_byte == 8'd0) ? ehts_pkg::STS_NO_DATA
                                                           : ehts_pkg::STS_OK;
                  nxt_state.phase    = ehts_pkg::PH_IDLE;
               end
               default: begin
                  nxt_state.phase = ehts_pkg::PH_IDLE;
               end
            endcase
         end
      end
      result.busy_res = nxt_state.phase != ehts_pkg::PH_IDLE;
   end

endmodule

>>> rtl/ec_host_transaction_sequencer.sv
// ============================================================================
// ec_host_transaction_sequencer
// Host side of the embedded-controller handshake: sequences read, write and
// query transactions over polled status samples.
// ============================================================================
//   Channel  Direction  Carries
//   req_     in         action, address, write_data, status_byte, data_byte
//   rsp_     out        port write, completion, read byte, busy flag
//   csr_     in         poll_limit write data
//
// Each item is processed as it is transferred, and its result is held in the
// result register on the next cycle; one item a cycle while req_ready is high.
// The rate is set by the single step of the phase logic and poll counter.
// req_ready stays high while the result register is empty or being emptied.
// Reset is synchronous: idle, poll counter zero, poll_limit 1000; csr_ready
// is always high.
module ec_host_transaction_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_status_byte,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_port_write_valid,
   output logic        rsp_port_is_data,
   output logic [7:0]  rsp_port_value,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status_code,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_busy_res,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   ehts_pkg::state_type  state_ff;
   ehts_pkg::state_type  state_in;
   ehts_pkg::result_type result_ff;
   ehts_pkg::result_type result_in;
   logic [15:0]          poll_limit_ff;
   logic                 rsp_valid_ff;
   logic                 req_xfer;

   // Handshakes.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Transaction step.
   ehts_step u_step (
      .cur_state   (state_ff),
      .poll_limit  (poll_limit_ff),
      .action      (req_action),
      .address     (req_address),
      .write_data  (req_write_data),
      .status_byte (req_status_byte),
      .data_byte   (req_data_byte),
      .nxt_state   (state_in),
      .result      (result_in)
   );

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff <= ehts_pkg::POLL_RESET;
      end else if (csr_valid) begin
         poll_limit_ff <= csr_data;
      end
   end

   // Transaction state, updated on each input transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: ehts_pkg::PH_IDLE, polls_left: '0,
                       held_address: '0, held_write_byte: '0};
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_port_write_valid = result_ff.port_write_valid;
   assign rsp_port_is_data     = result_ff.port_is_data;
   assign rsp_port_value       = result_ff.port_value;
   assign rsp_done_res         = result_ff.done_res;
   assign rsp_status_code      = result_ff.status_code;
   assign rsp_read_data        = result_ff.read_data;
   assign rsp_busy_res         = result_ff.busy_res;

endmodule

>>> rtl/ehts_checker.sv
// ============================================================================
// ehts_checker
// Port-level checks on the embedded-controller host sequencer results.
// ============================================================================
`include "ec_host_transaction_sequencer_defines.svh"

module ehts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_port_write_valid,
   input logic        rsp_port_is_data,
   input logic [7:0]  rsp_port_value,
   input logic        rsp_done_res,
   input logic [1:0]  rsp_status_code,
   input logic [7:0]  rsp_read_data,
   input logic        rsp_busy_res
);

   // A stalled result transfer holds its payload.
   `EHTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_port_value) && $stable(rsp_status_code) && $stable(rsp_read_data))

   // A non-zero completion code only comes with a finished transfer.
   `EHTS_ASSERT_SAME(a_code_done, rsp_valid && (rsp_status_code != ehts_pkg::STS_OK), rsp_done_res)

   // A finished transaction leaves the block idle; a rejection leaves it busy.
   `EHTS_ASSERT_SAME(a_done_idle, rsp_valid && rsp_done_res && (rsp_status_code != ehts_pkg::STS_REJECT), !rsp_busy_res)
   `EHTS_ASSERT_SAME(a_reject_busy, rsp_valid && rsp_done_res && (rsp_status_code == ehts_pkg::STS_REJECT), rsp_busy_res && !rsp_port_write_valid)

   // Without a port write the port fields are zero.
   `EHTS_ASSERT_SAME(a_port_idle, rsp_valid && !rsp_port_write_valid, !rsp_port_is_data && (rsp_port_value == 8'd0))

endmodule

bind ec_host_transaction_sequencer ehts_checker u_ehts_checker (.*);

>>> dv/ec_host_transaction_sequencer_checker.sv
// ----------------------------------------------------------------------------
// Embedded-controller host sequencer checker
// Watches the request, result and register channels. It keeps its own copy
// of the sequencer state and poll limit, works out the result of every
// request transfer and compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
module ec_host_transaction_sequencer_checker
   import ehts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_status_byte,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_port_write_valid,
   input  logic        rsp_port_is_data,
   input  logic [7:0]  rsp_port_value,
   input  logic        rsp_done_res,
   input  logic [1:0]  rsp_status_code,
   input  logic [7:0]  rsp_read_data,
   input  logic        rsp_busy_res,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending_count,
   output logic        txn_active
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_LIMIT = 40;

   // Our own view of the sequencer.
   state_type   seq_state;
   logic [15:0] poll_limit;
   result_type  expected_results[$];

   // Compares one field, and prints and counts a mismatch.
   task automatic check_field(input string what, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         if (fail_count < PRINT_LIMIT)
            $display("ERROR at %0t: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
         fail_count++;
      end
   endtask

   // Works out the completion of one status sample in a busy phase.
   function automatic void advance_on_sample(inout result_type res,
                                             input logic [7:0] status,
                                             input logic [7:0] data);
      logic condition_met;

      // The read byte and the query answer wait for a full output buffer,
      // everything else waits for an empty input buffer.
      if (seq_state.phase == PH_RD_ADDR || seq_state.phase == PH_QUERY)
         condition_met = status[ST_OBF_BIT];
      else
         condition_met = !status[ST_IBF_BIT];

      if (!condition_met) begin
         if (seq_state.polls_left <= 16'd1) begin
            seq_state.polls_left = '0;
            res.done_res         = 1'b1;
            res.status_code      = STS_TIMEOUT;
            seq_state.phase      = PH_IDLE;
         end else begin
            seq_state.polls_left = seq_state.polls_left - 16'd1;
         end
         return;
      end

      seq_state.polls_left = poll_limit;
      case (seq_state.phase)
         PH_RD_CMD, PH_WR_CMD: begin
            res.port_write_valid = 1'b1;
            res.port_is_data     = 1'b1;
            res.port_value       = seq_state.held_address;
            seq_state.phase      = (seq_state.phase == PH_RD_CMD) ? PH_RD_ADDR : PH_WR_ADDR;
         end
         PH_WR_ADDR: begin
            res.port_write_valid = 1'b1;
            res.port_is_data     = 1'b1;
            res.port_value       = seq_state.held_write_byte;
            seq_state.phase      = PH_WR_DATA;
         end
         PH_RD_ADDR: begin
            res.done_res    = 1'b1;
            res.status_code = STS_OK;
            res.read_data   = data;
            seq_state.phase = PH_IDLE;
         end
         PH_WR_DATA: begin
            res.done_res    = 1'b1;
            res.status_code = STS_OK;
            seq_state.phase = PH_IDLE;
         end
         PH_QUERY: begin
            res.done_res    = 1'b1;
            res.status_code = (data == 8'h00) ? STS_NO_DATA : STS_OK;
            res.read_data   = data;
            seq_state.phase = PH_IDLE;
         end
         default: seq_state.phase = PH_IDLE;
      endcase
   endfunction

   // Works out the result of one request transfer and updates the state.
   function automatic result_type sequence_step(input logic [2:0] action,
                                                input logic [7:0] address,
                                                input logic [7:0] write_data,
                                                input logic [7:0] status,
                                                input logic [7:0] data);
      result_type res;
      logic       busy;
      logic       is_request;

      res        = '0;
      busy       = (seq_state.phase != PH_IDLE);
      is_request = (action == ACT_READ) || (action == ACT_WRITE) || (action == ACT_QUERY)
                   || (action == ACT_SCI && status[ST_SCI_BIT]);

      if (is_request && busy) begin
         // A new transaction cannot start over one in progress.
         res.done_res    = 1'b1;
         res.status_code = STS_REJECT;
      end else if (is_request) begin
         res.port_write_valid = 1'b1;
         res.port_is_data     = 1'b0;
         seq_state.polls_left = poll_limit;
         if (action == ACT_READ) begin
            seq_state.held_address = address;
            res.port_value         = CMD_READ;
            seq_state.phase        = PH_RD_CMD;
         end else if (action == ACT_WRITE) begin
            seq_state.held_address    = address;
            seq_state.held_write_byte = write_data;
            res.port_value            = CMD_WRITE;
            seq_state.phase           = PH_WR_CMD;
         end else begin
            res.port_value  = CMD_QUERY;
            seq_state.phase = PH_QUERY;
         end
      end else if (action == ACT_SAMPLE && busy) begin
         advance_on_sample(res, status, data);
      end

      res.busy_res = (seq_state.phase != PH_IDLE);
      return res;
   endfunction

   // Result transfers are checked first, then request and register transfers
   // update the prediction; a request sees the poll limit from before the edge.
   always @(posedge clock) begin : channel_monitor
      result_type want;

      if (reset) begin
         seq_state       = '0;
         seq_state.phase = PH_IDLE;
         poll_limit      = POLL_RESET;
         fail_count      = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               check_field("result transfer with nothing outstanding", 16'd1, 16'd0);
            end else begin
               want = expected_results.pop_front();
               check_field("port_write_valid", 16'(rsp_port_write_valid),
                           16'(want.port_write_valid));
               check_field("port_is_data", 16'(rsp_port_is_data), 16'(want.port_is_data));
               check_field("port_value", 16'(rsp_port_value), 16'(want.port_value));
               check_field("done_res", 16'(rsp_done_res), 16'(want.done_res));
               check_field("status_code", 16'(rsp_status_code), 16'(want.status_code));
               check_field("read_data", 16'(rsp_read_data), 16'(want.read_data));
               check_field("busy_res", 16'(rsp_busy_res), 16'(want.busy_res));
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(sequence_step(req_action, req_address, req_write_data,
                                                     req_status_byte, req_data_byte));
         if (csr_valid && csr_ready)
            poll_limit = csr_data;
      end
      pending_count = expected_results.size();
      txn_active    = (seq_state.phase != PH_IDLE);
   end

endmodule

>>> dv/ec_host_transaction_sequencer_tb.sv
// ----------------------------------------------------------------------------
// Embedded-controller host sequencer testbench
// Drives read, write and query transactions as polled status samples, mixed
// with rejected requests and ignored items, over a range of poll limits.
// Both channels stall at random; the checker beside the block does the
// comparing and this module gives the verdict.
// ----------------------------------------------------------------------------
module ec_host_transaction_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ehts_pkg::*;

   localparam int          RANDOM_ITEMS = 1450;
   localparam int          DIRECTED     = 25;
   localparam int          NUM_SETTINGS = 8;
   localparam int          HOLD_CYCLES  = 80;
   localparam int          CYCLE_LIMIT  = 300000;
   localparam logic [7:0]  OBF_MASK     = 8'h01 << ST_OBF_BIT;
   localparam logic [7:0]  IBF_MASK     = 8'h01 << ST_IBF_BIT;
   localparam logic [7:0]  SCI_MASK     = 8'h01 << ST_SCI_BIT;
   localparam logic [15:0] LIMIT_SETTINGS [NUM_SETTINGS] =
      '{16'd1, 16'd0, 16'd65535, 16'd2, 16'd5, 16'd3, 16'd40, 16'd4};

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action      = '0;
   logic [7:0]  req_address     = '0;
   logic [7:0]  req_write_data  = '0;
   logic [7:0]  req_status_byte = '0;
   logic [7:0]  req_data_byte   = '0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic        rsp_port_write_valid;
   logic        rsp_port_is_data;
   logic [7:0]  rsp_port_value;
   logic        rsp_done_res;
   logic [1:0]  rsp_status_code;
   logic [7:0]  rsp_read_data;
   logic        rsp_busy_res;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data        = '0;

   int   fail_count;
   int   pending_count;
   logic txn_active;

   // Stimulus controls shared with the receiver process.
   bit quiet_mode      = 1'b0;
   bit hold_off_req    = 1'b0;
   int gap_pct         = 0;
   int items_sent      = 0;
   int effective_limit = 1000;
   int cycle_count;

   ec_host_transaction_sequencer DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_address          (req_address),
      .req_write_data       (req_write_data),
      .req_status_byte      (req_status_byte),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_port_write_valid (rsp_port_write_valid),
      .rsp_port_is_data     (rsp_port_is_data),
      .rsp_port_value       (rsp_port_value),
      .rsp_done_res         (rsp_done_res),
      .rsp_status_code      (rsp_status_code),
      .rsp_read_data        (rsp_read_data),
      .rsp_busy_res         (rsp_busy_res),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   ec_host_transaction_sequencer_checker sequencer_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_address          (req_address),
      .req_write_data       (req_write_data),
      .req_status_byte      (req_status_byte),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_port_write_valid (rsp_port_write_valid),
      .rsp_port_is_data     (rsp_port_is_data),
      .rsp_port_value       (rsp_port_value),
      .rsp_done_res         (rsp_done_res),
      .rsp_status_code      (rsp_status_code),
      .rsp_read_data        (rsp_read_data),
      .rsp_busy_res         (rsp_busy_res),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data),
      .fail_count           (fail_count),
      .pending_count        (pending_count),
      .txn_active           (txn_active)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Offers one request and holds it until the transfer. Called and left at
   // a falling edge; the valid stays high so that a following item can be
   // driven at once.
   task automatic send_item(input logic [2:0] action, input logic [7:0] address,
                            input logic [7:0] write_data, input logic [7:0] status,
                            input logic [7:0] data);
      int gap;

      gap = 0;
      if (!quiet_mode && $urandom_range(0, 99) < gap_pct)
         gap = $urandom_range(1, 14);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_action      = action;
      req_address     = address;
      req_write_data  = write_data;
      req_status_byte = status;
      req_data_byte   = data;
      req_valid       = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Any action, any field values.
   task automatic send_noise();
      send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
   endtask

   // A status sample: mostly one that lets the transaction move on, some
   // random, and only failing ones when a timeout is wanted.
   task automatic send_sample(input bit stuck);
      logic [7:0] status;
      logic [7:0] data;

      status = 8'($urandom_range(0, 255));
      if (stuck)
         status = (status & ~OBF_MASK) | IBF_MASK;
      else if ($urandom_range(0, 99) < 65)
         status = (status | OBF_MASK) & ~IBF_MASK;
      data = ($urandom_range(0, 99) < 12) ? 8'h00 : 8'($urandom_range(0, 255));
      send_item(ACT_SAMPLE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                status, data);
   endtask

   // One transaction from its request to its end, or a stray item.
   task automatic run_transaction();
      int pick;
      int guard;
      bit stuck;

      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         send_noise();
         return;
      end
      if (pick < 35)
         send_item(ACT_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else if (pick < 60)
         send_item(ACT_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else if (pick < 80)
         send_item(ACT_QUERY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else
         send_item(ACT_SCI, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)) | SCI_MASK, 8'($urandom_range(0, 255)));

      stuck = (effective_limit <= 6) && ($urandom_range(0, 4) == 0);
      for (guard = 0; txn_active && guard < 200; guard++) begin
         if ($urandom_range(0, 99) < 6)
            send_noise();
         else
            send_sample(stuck);
      end
   endtask

   // Stops offering and waits for every outstanding result.
   task automatic wait_results_drained();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Writes the poll limit once the block has nothing in flight.
   task automatic write_poll_limit(input logic [15:0] value);
      wait_results_drained();
      csr_data  = value;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid       = 1'b0;
      effective_limit = (value == 16'd0) ? 1 : value;
   endtask

   // Result side: random stall bursts in stretches of varying density, and a
   // single long hold-off when the stimulus asks for one.
   initial begin : result_receiver
      int stall_pct;
      int stretch_left;
      int hold_count;
      bit hold_done;

      stall_pct    = 0;
      stretch_left = 0;
      hold_done    = 1'b0;
      forever begin
         @(negedge clock);
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(40, 160);
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 6;
               default: stall_pct = 25;
            endcase
         end
         stretch_left--;
         if (hold_off_req && !hold_done) begin
            rsp_ready = 1'b0;
            for (hold_count = 1; hold_count < HOLD_CYCLES; hold_count++)
               @(negedge clock);
            hold_done = 1'b1;
         end else if (!quiet_mode && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Run limit.
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("ec_host_transaction_sequencer test failed");
      $finish;
   end

   initial begin : stimulus
      int         setting;
      int         phase_target;
      logic [15:0] limit;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Ignored items while idle: a status sample, an SCI event without its
      // flag and the unused actions.
      send_item(ACT_SAMPLE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(ACT_SCI, 8'hFF, 8'hFF, ~SCI_MASK, 8'hFF);
      send_item(3'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(3'd6, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

      // Read at the top address, with a failed poll in each wait and a
      // request rejected on the way.
      send_item(ACT_READ, 8'hFF, 8'h00, 8'h00, 8'h00);
      send_item(ACT_SAMPLE, 8'h00, 8'h00, IBF_MASK, 8'h00);
      send_item(ACT_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(ACT_SAMPLE, 8'h00, 8'h00, 8'h00, 8'hFF);
      send_item(ACT_SAMPLE, 8'h00, 8'h00, OBF_MASK, 8'hFF);

      // Write, with an SCI event rejected while busy.
      send_item(ACT_WRITE, 8'h00, 8'hFF, 8'h00, 8'h00);
      send_item(ACT_SAMPLE, 8'hFF, 8'h00, ~IBF_MASK, 8'hFF);
      send_item(ACT_SCI, 8'h00, 8'h00, 8'hFF, 8'h00);
      send_item(ACT_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(ACT_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);

      // Query started by an SCI event that returns nothing.
      send_item(ACT_SCI, 8'h00, 8'h00, SCI_MASK, 8'h00);
      send_item(ACT_SAMPLE, 8'h00, 8'h00, OBF_MASK, 8'h00);

      // Query request answered, with a write rejected while busy.
      send_item(ACT_QUERY, 8'hFF, 8'hFF, 8'h00, 8'h00);
      send_item(ACT_WRITE, 8'h5A, 8'hA5, 8'h00, 8'h00);
      send_item(ACT_SAMPLE, 8'h00, 8'h00, 8'hFF, 8'h5A);

      // Write of a zero byte at a mixed address.
      send_item(ACT_WRITE, 8'hA5, 8'h00, 8'h00, 8'h00);
      send_item(ACT_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(ACT_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(ACT_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);

      // Random transactions under each poll limit in turn.
      for (setting = 0; setting < NUM_SETTINGS; setting++) begin
         limit = LIMIT_SETTINGS[setting];
         if (setting == NUM_SETTINGS - 2)
            limit = 16'($urandom_range(8, 300));
         write_poll_limit(limit);
         case (setting % 3)
            0:       gap_pct = 0;
            1:       gap_pct = 10;
            default: gap_pct = 35;
         endcase
         quiet_mode = (setting == NUM_SETTINGS - 1);
         if (setting == 3)
            hold_off_req = 1'b1;

         // With one poll allowed, the first failing sample times out.
         if (effective_limit == 1) begin
            send_item(ACT_READ, 8'h3C, 8'h00, 8'h00, 8'h00);
            send_item(ACT_SAMPLE, 8'h00, 8'h00, IBF_MASK, 8'h00);
         end

         phase_target = DIRECTED + (setting + 1) * RANDOM_ITEMS / NUM_SETTINGS;
         while (items_sent < phase_target)
            run_transaction();
      end

      wait_results_drained();
      repeat (4) @(negedge clock);
      if (fail_count == 0)
         $display("ec_host_transaction_sequencer test passed");
      else
         $display("ec_host_transaction_sequencer test failed");
      $finish;
   end

endmodule
